/* sv/ilb_pkg.sv */
// Shared types and codes for the indexed list buffer.
// Used by ilb_ctrl and indexed_list_buffer; no dependencies.
package ilb_pkg;

  typedef logic [2:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_APPEND  = 3'd0;
  localparam action_t ACT_INSERT  = 3'd1;
  localparam action_t ACT_REMOVE  = 3'd2;
  localparam action_t ACT_REMLAST = 3'd3;
  localparam action_t ACT_READ    = 3'd4;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  localparam int unsigned POS_W   = 4;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

endpackage

/* sv/indexed_list_buffer.sv */
// Indexed list buffer: ordered list of up to DEPTH words with append,
// insert, remove, remove-last and read. Uses ilb_ctrl and ilb_mem.
// Append and failed requests go straight to the result; read and remove-last read one
// entry first; insert and remove shift entries one entry per shift cycle.
// Throughput: one transaction at a time, next one taken as the result appears; a result
// waits while out_stall holds the one before it. Reset: count zero, entries kept.
module indexed_list_buffer
  import ilb_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  action_t            in_action,
  input  logic [POS_W-1:0]   in_position,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_word,
  output status_t            out_status,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_empty_res
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [WIDTH-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic [WIDTH-1:0] mem_rd_data;

  ilb_ctrl #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_empty_res (out_empty_res),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

  ilb_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

/* sv/ilb_mem.sv */
// Entry store for the indexed list buffer: one write port, one read port,
// registered read data. No dependencies.
module ilb_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/ilb_ctrl.sv */
// Sequencer for the indexed list buffer: request decode, entry count,
// one-entry-per-cycle shifting through ilb_mem, and the result register.
// Depends on ilb_pkg.
module ilb_ctrl
  import ilb_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  action_t                  in_action,
  input  logic [POS_W-1:0]         in_position,
  input  logic [VALUE_W-1:0]       in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VALUE_W-1:0]       out_word,
  output status_t                  out_status,
  output logic [COUNT_W-1:0]       out_count,
  output logic                     out_empty_res,
  output logic                     mem_wr_en,
  output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
  output logic [WIDTH-1:0]         mem_wr_data,
  output logic                     mem_rd_en,
  output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
  input  logic [WIDTH-1:0]         mem_rd_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP     = 3'd1;
  localparam logic [2:0] S_UPLAST = 3'd2;
  localparam logic [2:0] S_DN     = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               first_r, first_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [WIDTH-1:0]   val_r, val_nxt;
  logic [WIDTH-1:0]   word_r, word_nxt;
  status_t            st_r, st_nxt;
  logic [VALUE_W-1:0] out_word_r, out_word_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_empty_r, out_empty_nxt;

  logic          full;
  logic          empty;
  logic          pos_bad;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] cnt_a;
  logic [AW-1:0] last_a;
  logic [CW-1:0] cnt_m1;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign pos_bad = XW'(in_position) >= XW'(cnt_r);
  assign pos_a   = AW'(in_position);
  assign cnt_a   = AW'(cnt_r);
  assign cnt_m1  = cnt_r - CW'(1);
  assign last_a  = AW'(cnt_m1);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    first_nxt      = first_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    word_nxt       = word_r;
    st_nxt         = st_r;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = '0;
    mem_wr_data    = val_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt   = pos_a;
          val_nxt   = WIDTH'(in_value);
          word_nxt  = '0;
          st_nxt    = ST_OK;
          first_nxt = 1'b1;
          state_nxt = S_FIN;
          case (in_action)
            ACT_APPEND: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_a;
                mem_wr_data = WIDTH'(in_value);
                cnt_nxt     = cnt_r + CW'(1);
              end
            end
            ACT_INSERT: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else if (pos_bad) begin
                st_nxt = ST_BAD;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = last_a;
                idx_nxt     = last_a;
                state_nxt   = S_UP;
              end
            end
            ACT_REMOVE: begin
              if (pos_bad) begin
                st_nxt = ST_BAD;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_a;
                idx_nxt     = pos_a;
                state_nxt   = S_DN;
              end
            end
            ACT_REMLAST: begin
              if (empty) begin
                st_nxt = ST_BAD;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = last_a;
                cnt_nxt     = cnt_m1;
                state_nxt   = S_RD;
              end
            end
            ACT_READ: begin
              if (pos_bad) begin
                st_nxt = ST_BAD;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_a;
                state_nxt   = S_RD;
              end
            end
            default: st_nxt = ST_BAD;
          endcase
        end
      end
      // read data holds entry idx_r; it moves up one slot
      S_UP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r + AW'(1);
        mem_wr_data = mem_rd_data;
        if (idx_r == pos_r) begin
          state_nxt = S_UPLAST;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r - AW'(1);
          idx_nxt     = idx_r - AW'(1);
        end
      end
      S_UPLAST: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r;
        mem_wr_data = val_r;
        cnt_nxt     = cnt_r + CW'(1);
        state_nxt   = S_FIN;
      end
      // first read is the removed word, later ones move down one slot
      S_DN: begin
        if (first_r) begin
          word_nxt  = mem_rd_data;
          first_nxt = 1'b0;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = idx_r - AW'(1);
          mem_wr_data = mem_rd_data;
        end
        if (CW'(idx_r) == cnt_m1) begin
          cnt_nxt   = cnt_m1;
          state_nxt = S_FIN;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r + AW'(1);
          idx_nxt     = idx_r + AW'(1);
        end
      end
      S_RD: begin
        word_nxt  = mem_rd_data;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = VALUE_W'(word_r);
          out_status_nxt = st_r;
          out_count_nxt  = COUNT_W'(cnt_r);
          out_empty_nxt  = empty;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    word_r       <= word_nxt;
    st_r         <= st_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign in_stall      = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("read and write hit the same entry");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1) || cnt_r + CW'(1) == $past(cnt_r)))
    else $error("entry count moved by more than one");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("finished transaction not delivered");

endmodule

/* dv/ilb_checker.sv */
// Checker for the indexed list buffer: keeps a shadow copy of the list,
// predicts one result per accepted request and compares each returned result.
// Depends on ilb_pkg for the action and status codes and the field widths.
module ilb_checker
  import ilb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  action_t            in_action,
  input  logic [POS_W-1:0]   in_position,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [VALUE_W-1:0] out_word,
  input  status_t            out_status,
  input  logic [COUNT_W-1:0] out_count,
  input  logic               out_empty_res,
  output int unsigned        mismatches,
  output int unsigned        outstanding
);

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned LIST_AW    = $clog2(LIST_DEPTH);

  typedef struct packed {
    logic [VALUE_W-1:0] word;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } list_result_t;

  logic [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
  logic [COUNT_W-1:0] shadow_len;
  list_result_t       expected_q [$];

  // Applies one request to the shadow list and returns the result it yields.
  function automatic list_result_t apply_request(input action_t act,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VALUE_W-1:0] val);
    list_result_t res;
    int i;
    res.word   = '0;
    res.status = ST_OK;
    case (act)
      ACT_APPEND: begin
        if (shadow_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[LIST_AW'(shadow_len)] = val;
          shadow_len++;
        end
      end
      ACT_INSERT: begin
        // full check wins over the position check
        if (shadow_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (pos >= shadow_len) begin
          res.status = ST_BAD;
        end else begin
          for (i = shadow_len; i > pos; i--)
            shadow_entries[LIST_AW'(i)] = shadow_entries[LIST_AW'(i-1)];
          shadow_entries[pos] = val;
          shadow_len++;
        end
      end
      ACT_REMOVE: begin
        if (pos >= shadow_len) begin
          res.status = ST_BAD;
        end else begin
          res.word = shadow_entries[pos];
          for (i = pos; i + 1 < shadow_len; i++)
            shadow_entries[LIST_AW'(i)] = shadow_entries[LIST_AW'(i+1)];
          shadow_len--;
        end
      end
      ACT_REMLAST: begin
        if (shadow_len == 0) begin
          res.status = ST_BAD;
        end else begin
          shadow_len--;
          res.word = shadow_entries[LIST_AW'(shadow_len)];
        end
      end
      ACT_READ: begin
        if (pos >= shadow_len) res.status = ST_BAD;
        else res.word = shadow_entries[pos];
      end
      default: res.status = ST_BAD;
    endcase
    res.count     = shadow_len;
    res.empty_res = (shadow_len == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      shadow_len = '0;
      expected_q.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      // results belong to older transactions, so retire before queuing new ones
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: word %h status %0d count %0d",
                 out_word, out_status, out_count);
          bad++;
        end else begin
          want = expected_q.pop_front();
          if (out_word !== want.word) begin
            $error("word: expected %h, got %h", want.word, out_word);
            bad++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            bad++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_count);
            bad++;
          end
          if (out_empty_res !== want.empty_res) begin
            $error("empty_res: expected %0b, got %0b", want.empty_res, out_empty_res);
            bad++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(apply_request(in_action, in_position, in_value));
      mismatches  <= mismatches + bad;
      outstanding <= expected_q.size();
    end
  end

endmodule

/* dv/indexed_list_buffer_test.sv */
// Testbench top for indexed_list_buffer: drives directed and random list
// requests with random idling on both channels and gives the verdict.
// Depends on ilb_pkg, indexed_list_buffer and ilb_checker.
module indexed_list_buffer_test;
  import ilb_pkg::*;

  localparam int      LIST_DEPTH     = 16;
  localparam int      RANDOM_ITEMS   = 1625;
  localparam action_t ACT_SPARE_LAST = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  action_t            in_action;
  logic [POS_W-1:0]   in_position;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic [VALUE_W-1:0] out_word;
  status_t            out_status;
  logic [COUNT_W-1:0] out_count;
  logic               out_empty_res;
  int unsigned        mismatches;
  int unsigned        outstanding;

  int fill;     // rough list occupancy, only used to shape stimulus
  bit quiet;    // no idling on either side while set
  bit growing;

  always #10 clk = ~clk;

  indexed_list_buffer u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

  ilb_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_empty_res (out_empty_res),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (fill > 0 && $urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, fill - 1));
    return POS_W'($urandom_range(0, LIST_DEPTH - 1));
  endfunction

  function automatic action_t pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return action_t'($urandom_range(ACT_READ + 1, ACT_SPARE_LAST));
    if (growing) begin
      if (r < 40) return ACT_APPEND;
      if (r < 65) return ACT_INSERT;
      if (r < 75) return ACT_REMOVE;
      if (r < 80) return ACT_REMLAST;
      return ACT_READ;
    end
    if (r < 15) return ACT_APPEND;
    if (r < 25) return ACT_INSERT;
    if (r < 55) return ACT_REMOVE;
    if (r < 75) return ACT_REMLAST;
    return ACT_READ;
  endfunction

  // Returns at the clock edge where the transaction was accepted.
  task automatic send_request(input action_t act, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] val);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (act)
      ACT_APPEND:  if (fill < LIST_DEPTH) fill++;
      ACT_INSERT:  if (fill < LIST_DEPTH && pos < fill) fill++;
      ACT_REMOVE:  if (pos < fill) fill--;
      ACT_REMLAST: if (fill > 0) fill--;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_action   <= ACT_APPEND;
    in_position <= '0;
    in_value    <= '0;
    fill    = 0;
    quiet   = 1'b0;
    growing = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corner cases
    send_request(ACT_REMLAST, '0, '0);
    send_request(ACT_READ, POS_W'(LIST_DEPTH - 1), '0);
    send_request(ACT_INSERT, '0, '1);
    send_request(ACT_SPARE_LAST, '0, '1);
    for (int i = 0; i < LIST_DEPTH; i++)
      send_request(ACT_APPEND, '0, (i == 0) ? '0 : (i == 1) ? '1 : $urandom);
    // full list: both growth requests fail, insert with a good position too
    send_request(ACT_APPEND, '0, '1);
    send_request(ACT_INSERT, POS_W'(LIST_DEPTH - 1), '1);
    send_request(ACT_READ, POS_W'(LIST_DEPTH - 1), '0);
    send_request(ACT_REMOVE, '0, '0);
    send_request(ACT_INSERT, '0, '1);
    send_request(ACT_REMOVE, POS_W'(LIST_DEPTH - 1), '0);
    send_request(ACT_READ, POS_W'(LIST_DEPTH - 1), '0);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (i % 400 == 399) drain();
      if ((fill == LIST_DEPTH && growing) || (fill == 0 && !growing)) begin
        if ($urandom_range(0, 3) == 0) growing = !growing;
      end else if ($urandom_range(0, 99) == 0) begin
        growing = !growing;
      end
      send_request(pick_action(), pick_pos(), pick_value());
    end
    drain();
    repeat (40) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
sv/ilb_pkg.sv
sv/ilb_mem.sv
sv/ilb_ctrl.sv
sv/indexed_list_buffer.sv
dv/ilb_checker.sv
dv/indexed_list_buffer_test.sv
